// ----- hdl/wsg_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the wavetable sound generator.
package wsg_pkg;

    localparam int STORE_DEPTH  = 128;
    localparam int STORE_ADDR_W = 7;
    localparam int BYTE_W       = 8;
    localparam int AMP_W        = 4;
    localparam int PERIOD_W     = 12;
    localparam int VOL_W        = 15;
    localparam int LEVEL_W      = 16;

    localparam int WAVE_PEAK   = 128;
    localparam int AMP_PEAK    = 15;
    localparam int VOL_PEAK    = 32767;
    localparam int MIX_DIVISOR = 255 * 15 * 5;
    localparam int LAST_WAVE   = 3;

    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;

    localparam logic [7:0] ADDR_PERIOD_BASE = 8'h80;
    localparam logic [7:0] ADDR_AMP_BASE    = 8'h8A;
    localparam logic [7:0] ADDR_ENABLE      = 8'h8F;
    localparam logic [7:0] READ_FILL        = 8'hFF;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] address;
        logic [7:0] write_value;
    } wsg_in_t;

    typedef struct packed {
        logic [7:0]         read_data;
        logic signed [15:0] sample;
    } wsg_out_t;

    typedef struct packed {
        logic               done;
        logic signed [15:0] level;
    } wsg_mix_t;

endpackage

// ----- hdl/wavetable_sound_generator.sv -----
`timescale 1ns / 1ps
// Top level of the wavetable sound generator: bus decode, voice state and item sequencer.
// Takes one item at a time and holds s_ready low until the item's result is registered. A bus
// read goes through the execute, read-data and finish states; a tick that does not advance the
// voices, a silent tick and an unknown request go from the execute state straight to finish. A
// bus write and a tick that advances the voices recompute the mix: the item is applied, then the
// shared multiply-accumulate visits one voice per cycle through the single read port of the
// waveform store, followed by the multiply by the master volume, the magnitude, the reciprocal
// multiply for the division by the mix divisor, the hand-back of the level and the registering
// of the result. The next item can be accepted in the cycle after a result is registered. A
// master volume write recomputes the mix as well and keeps s_ready low until the mix is done.
// The waveform store needs no clearing pass after reset.
// A result waiting on the output register does not stop the next item from being accepted;
// it holds back only that item's result.
module wavetable_sound_generator #(
    parameter int VOICES         = 5,
    parameter int WAVE_LENGTH    = 32,
    parameter int TICKS_PER_STEP = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  wsg_pkg::wsg_in_t              s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output wsg_pkg::wsg_out_t             m_data,
    input  logic                          cfg_we,
    input  logic [wsg_pkg::VOL_W-1:0]     cfg_wdata
);
    import wsg_pkg::*;

    localparam int OFF_W  = $clog2(WAVE_LENGTH);
    localparam int VSEL_W = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int TD_W   = (TICKS_PER_STEP > 1) ? $clog2(TICKS_PER_STEP) : 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RDATA,
        ST_KICK,
        ST_WAIT,
        ST_FIN
    } state_t;

    state_t                               state_reg, state_next;
    wsg_in_t                              item_reg;
    logic                                 cfg_eval_reg;
    logic                                 silent_reg;
    logic [BYTE_W-1:0]                    rd_val_reg;
    logic signed [LEVEL_W-1:0]            level_reg;
    logic [VOL_W-1:0]                     vol_reg;
    logic [VOICES-1:0][PERIOD_W-1:0]      period_reg;
    logic [VOICES-1:0][PERIOD_W-1:0]      count_reg;
    logic [VOICES-1:0][AMP_W-1:0]         amp_reg;
    logic [VOICES-1:0][OFF_W-1:0]         offset_reg;
    logic [VOICES-1:0]                    enable_reg;
    logic [TD_W-1:0]                      tdiv_reg;
    logic                                 m_valid_reg;
    wsg_out_t                             m_data_reg;

    logic [7:0]                           per_off;
    logic [7:0]                           amp_off;
    logic [2:0]                           per_v;
    logic [2:0]                           amp_v;
    logic                                 is_period;
    logic                                 is_amp;
    logic                                 mem_we;
    logic [STORE_ADDR_W-1:0]              mem_raddr;
    logic [BYTE_W-1:0]                    mem_rdata;
    logic [STORE_ADDR_W-1:0]              mix_addr;
    logic                                 mix_start;
    wsg_mix_t                             mix_res;
    logic                                 s_fire;
    logic                                 out_free;

    assign s_ready  = (state_reg == ST_IDLE) && !cfg_we;
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    always_comb begin
        per_off   = item_reg.address - ADDR_PERIOD_BASE;
        amp_off   = item_reg.address - ADDR_AMP_BASE;
        per_v     = per_off[3:1];
        amp_v     = amp_off[2:0];
        is_period = (item_reg.address >= ADDR_PERIOD_BASE) && (item_reg.address < ADDR_AMP_BASE)
                    && (int'(per_v) < VOICES);
        is_amp    = (item_reg.address >= ADDR_AMP_BASE) && (item_reg.address < ADDR_ENABLE)
                    && (int'(amp_v) < VOICES);
        mem_we    = (state_reg == ST_EXEC) && (item_reg.req_type == REQ_WRITE)
                    && !item_reg.address[7];
        mem_raddr = (state_reg == ST_EXEC) ? item_reg.address[STORE_ADDR_W-1:0] : mix_addr;
        mix_start = (state_reg == ST_KICK);
    end

    wsg_wave_mem u_wave_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .we      (mem_we),
        .waddr   (item_reg.address[STORE_ADDR_W-1:0]),
        .wdata   (item_reg.write_value),
        .raddr   (mem_raddr),
        .rdata   (mem_rdata)
    );

    wsg_mix_unit #(
        .VOICES      (VOICES),
        .WAVE_LENGTH (WAVE_LENGTH)
    ) u_mix_unit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mix_start),
        .enable  (enable_reg),
        .amp     (amp_reg),
        .offset  (offset_reg),
        .volume  (vol_reg),
        .rd_addr (mix_addr),
        .rd_data (mem_rdata),
        .result  (mix_res)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (cfg_we) begin
                    state_next = ST_KICK;
                end else if (s_fire) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                unique case (item_reg.req_type)
                    REQ_WRITE: state_next = ST_KICK;
                    REQ_READ:  state_next = ST_RDATA;
                    REQ_TICK: begin
                        if (enable_reg != '0 && tdiv_reg == '0) begin
                            state_next = ST_KICK;
                        end else begin
                            state_next = ST_FIN;
                        end
                    end
                    default:   state_next = ST_FIN;
                endcase
            end
            ST_RDATA: state_next = ST_FIN;
            ST_KICK:  state_next = ST_WAIT;
            ST_WAIT: begin
                if (mix_res.done) begin
                    state_next = cfg_eval_reg ? ST_IDLE : ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cfg_eval_reg <= 1'b0;
            silent_reg   <= 1'b0;
            rd_val_reg   <= '0;
            level_reg    <= '0;
            vol_reg      <= '0;
            period_reg   <= '0;
            count_reg    <= '0;
            amp_reg      <= '0;
            offset_reg   <= '0;
            enable_reg   <= '0;
            tdiv_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_FIN && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_we) begin
                vol_reg <= cfg_wdata;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    cfg_eval_reg <= cfg_we;
                    silent_reg   <= 1'b0;
                    rd_val_reg   <= '0;
                    if (s_fire) begin
                        item_reg <= s_data;
                    end
                end
                ST_EXEC: begin
                    if (item_reg.req_type == REQ_WRITE) begin
                        if (is_period) begin
                            if (!item_reg.address[0]) begin
                                period_reg[per_v[VSEL_W-1:0]][7:0] <= item_reg.write_value;
                            end else begin
                                period_reg[per_v[VSEL_W-1:0]][PERIOD_W-1:8] <=
                                    item_reg.write_value[PERIOD_W-9:0];
                            end
                        end else if (is_amp) begin
                            amp_reg[amp_v[VSEL_W-1:0]] <= item_reg.write_value[AMP_W-1:0];
                        end else if (item_reg.address == ADDR_ENABLE) begin
                            enable_reg <= item_reg.write_value[VOICES-1:0];
                        end
                    end else if (item_reg.req_type == REQ_TICK) begin
                        if (enable_reg == '0) begin
                            silent_reg <= 1'b1;
                        end else begin
                            if (tdiv_reg == '0) begin
                                for (int v = 0; v < VOICES; v++) begin
                                    if (count_reg[v] != '0) begin
                                        count_reg[v] <= count_reg[v] - 1'b1;
                                    end else begin
                                        count_reg[v]  <= period_reg[v];
                                        offset_reg[v] <=
                                            (offset_reg[v] == OFF_W'(WAVE_LENGTH - 1)) ?
                                            '0 : offset_reg[v] + 1'b1;
                                    end
                                end
                            end
                            tdiv_reg <= (tdiv_reg == TD_W'(TICKS_PER_STEP - 1)) ?
                                        '0 : tdiv_reg + 1'b1;
                        end
                    end
                end
                ST_RDATA: begin
                    rd_val_reg <= item_reg.address[7] ? READ_FILL : mem_rdata;
                end
                ST_WAIT: begin
                    if (mix_res.done) begin
                        level_reg <= mix_res.level;
                    end
                end
                ST_FIN: begin
                    if (out_free) begin
                        m_data_reg.read_data <= rd_val_reg;
                        m_data_reg.sample    <= silent_reg ? '0 : level_reg;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// ----- hdl/wsg_wave_mem.sv -----
`timescale 1ns / 1ps
// Waveform byte store with per-entry valid bits and a registered read port.
module wsg_wave_mem (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              we,
    input  logic [wsg_pkg::STORE_ADDR_W-1:0]  waddr,
    input  logic [wsg_pkg::BYTE_W-1:0]        wdata,
    input  logic [wsg_pkg::STORE_ADDR_W-1:0]  raddr,
    output logic [wsg_pkg::BYTE_W-1:0]        rdata
);
    import wsg_pkg::*;

    logic [BYTE_W-1:0]      mem [STORE_DEPTH];
    logic [STORE_DEPTH-1:0] valid_reg;
    logic [BYTE_W-1:0]      rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (we) begin
            valid_reg[waddr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= valid_reg[raddr] ? mem[raddr] : '0;
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/wsg_mix_unit.sv -----
`timescale 1ns / 1ps
// Mix sequencer: shared multiply-accumulate over the voices, volume scale, reciprocal divide.
module wsg_mix_unit #(
    parameter int VOICES      = 5,
    parameter int WAVE_LENGTH = 32
) (
    input  logic                                                aclk,
    input  logic                                                aresetn,
    input  logic                                                start,
    input  logic [VOICES-1:0]                                   enable,
    input  logic [VOICES-1:0][wsg_pkg::AMP_W-1:0]               amp,
    input  logic [VOICES-1:0][$clog2(WAVE_LENGTH)-1:0]          offset,
    input  logic [wsg_pkg::VOL_W-1:0]                           volume,
    output logic [wsg_pkg::STORE_ADDR_W-1:0]                    rd_addr,
    input  logic [wsg_pkg::BYTE_W-1:0]                          rd_data,
    output wsg_pkg::wsg_mix_t                                   result
);
    import wsg_pkg::*;

    localparam int VSEL_W  = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int CNT_W   = $clog2(VOICES + 1);
    localparam int ACC_W   = $clog2(VOICES * WAVE_PEAK * AMP_PEAK) + 1;
    localparam int PROD_W  = ACC_W + VOL_W + 1;
    localparam int QUO_W   = $clog2(VOICES * WAVE_PEAK * AMP_PEAK * VOL_PEAK / MIX_DIVISOR + 1);
    localparam int MAG_W   = $clog2(VOICES * WAVE_PEAK * AMP_PEAK * VOL_PEAK + 1);
    localparam int DIV_LOG = $clog2(MIX_DIVISOR);
    localparam int RSH     = MAG_W + DIV_LOG;
    localparam int RECIP_W = MAG_W + 1;
    localparam int QPROD_W = MAG_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << RSH) + 64'(MIX_DIVISOR) - 64'd1) / 64'(MIX_DIVISOR));
    localparam logic [7:0]       WL8      = 8'(WAVE_LENGTH);

    typedef enum logic [2:0] {
        M_IDLE,
        M_MIX,
        M_SCALE,
        M_LOAD,
        M_DIV,
        M_DONE
    } mix_state_t;

    mix_state_t               state_reg, state_next;
    logic [CNT_W-1:0]         cnt_reg;
    logic [VSEL_W-1:0]        pv_reg;
    logic                     pend_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [MAG_W-1:0]         mag_reg;
    logic [QPROD_W-1:0]       qprod_reg;
    logic                     neg_reg;

    logic [VSEL_W-1:0]        vsel;
    logic [1:0]               wave_sel;
    logic [7:0]               base;
    logic signed [12:0]       term;
    logic signed [PROD_W-1:0] prod_full;
    logic [PROD_W-1:0]        mag;
    logic [QUO_W-1:0]         quo;

    always_comb begin
        vsel     = (int'(cnt_reg) < VOICES) ? cnt_reg[VSEL_W-1:0] : '0;
        wave_sel = (int'(vsel) < LAST_WAVE) ? 2'(vsel) : 2'(LAST_WAVE);
        base     = 8'(wave_sel) * WL8;
        rd_addr  = STORE_ADDR_W'(base + 8'(offset[vsel]));
        term      = $signed(rd_data) * $signed({1'b0, amp[pv_reg]});
        prod_full = acc_reg * $signed({1'b0, volume});
        mag       = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);
        quo       = qprod_reg[RSH +: QUO_W];
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            M_IDLE:  if (start) state_next = M_MIX;
            M_MIX:   if (int'(cnt_reg) == VOICES) state_next = M_SCALE;
            M_SCALE: state_next = M_LOAD;
            M_LOAD:  state_next = M_DIV;
            M_DIV:   state_next = M_DONE;
            M_DONE:  state_next = M_IDLE;
            default: state_next = M_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= M_IDLE;
            cnt_reg   <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            unique case (state_reg)
                M_IDLE: begin
                    cnt_reg  <= '0;
                    pend_reg <= 1'b0;
                    acc_reg  <= '0;
                end
                M_MIX: begin
                    if (pend_reg && enable[pv_reg]) begin
                        acc_reg <= acc_reg + ACC_W'(term);
                    end
                    if (int'(cnt_reg) < VOICES) begin
                        pv_reg   <= vsel;
                        pend_reg <= 1'b1;
                        cnt_reg  <= cnt_reg + 1'b1;
                    end else begin
                        pend_reg <= 1'b0;
                    end
                end
                M_SCALE: begin
                    prod_reg <= prod_full;
                end
                M_LOAD: begin
                    neg_reg <= prod_reg[PROD_W-1];
                    mag_reg <= MAG_W'(mag);
                end
                M_DIV: begin
                    qprod_reg <= QPROD_W'(mag_reg) * QPROD_W'(RECIP);
                end
                M_DONE: begin
                    cnt_reg <= '0;
                end
                default: begin
                    cnt_reg <= '0;
                end
            endcase
        end
    end

    always_comb begin
        result.done  = (state_reg == M_DONE);
        result.level = neg_reg ? -$signed(LEVEL_W'(quo)) : $signed(LEVEL_W'(quo));
    end

endmodule

// ----- hdl/wsg_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks of the wavetable sound generator and their binding.
module wsg_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_valid,
    input logic                       s_ready,
    input logic                       m_valid,
    input logic                       m_ready,
    input wsg_pkg::wsg_out_t          m_data,
    input logic                       cfg_we
);

    a_reset_no_result: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result shown straight after reset");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result dropped or changed");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("item accepted while the previous one is in work");

    a_busy_after_cfg: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_we |=> !s_ready)
        else $error("volume change not applied before next item");

    a_no_accept_on_cfg: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_we |-> !(s_valid && s_ready))
        else $error("item accepted together with a volume write");

endmodule

bind wavetable_sound_generator wsg_checker u_wsg_checker (.*);
